// File: src/chacha_pkg.sv
package chacha_pkg;

	localparam int unsigned DOUBLE_ROUNDS_DEF = 10;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNTER = 3'd6;

	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	typedef struct packed {
		logic [63:0] data_word;
		logic [3:0]  byte_count;
		logic        last_word;
	} item_t;

	typedef struct packed {
		logic [63:0] result_word;
		logic [3:0]  result_bytes;
		logic        result_last;
	} result_t;

	typedef logic [15:0][31:0] state_t;
	typedef logic [3:0][63:0]  key_t;

	function automatic state_t init_state(input key_t key, input logic [63:0] nonce_low,
			input logic [31:0] nonce_high, input logic [31:0] ctr);
		state_t s;
		s[0]  = SIGMA0;
		s[1]  = SIGMA1;
		s[2]  = SIGMA2;
		s[3]  = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			s[4 + 2 * i] = key[i][31:0];
			s[5 + 2 * i] = key[i][63:32];
		end
		s[12] = ctr;
		s[13] = nonce_low[31:0];
		s[14] = nonce_low[63:32];
		s[15] = nonce_high;
		return s;
	endfunction

	function automatic logic [31:0] rotl_step(input logic [31:0] v, input logic [1:0] step);
		logic [31:0] r;
		case (step)
			2'd0:    r = {v[15:0], v[31:16]};
			2'd1:    r = {v[19:0], v[31:20]};
			2'd2:    r = {v[23:0], v[31:24]};
			default: r = {v[24:0], v[31:25]};
		endcase
		return r;
	endfunction

	function automatic logic [3:0] clamp_count(input logic [3:0] cnt);
		logic [3:0] c;
		if (cnt == 4'd0) begin
			c = 4'd1;
		end else if (cnt > 4'd8) begin
			c = 4'd8;
		end else begin
			c = cnt;
		end
		return c;
	endfunction

	function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
		logic [63:0] m;
		for (int i = 0; i < 8; i++) begin
			m[8 * i +: 8] = {8{4'(i) < cnt}};
		end
		return m;
	endfunction

endpackage

// File: src/chacha20_stream_cipher_top.sv
// ChaCha20 keystream XOR over 64-bit little-endian words. A word that needs no new keystream
// block goes from S_IDLE straight to S_EMIT, which registers its result, and the next word is
// taken only after S_EMIT has returned to S_IDLE. At the first word of a message and at every
// eighth word a 64-byte block is generated first in S_LOAD, S_ROUND and S_FINAL, before that
// word goes to S_EMIT; here too the next word is taken only after S_EMIT. A block is made of a state
// load, the column and diagonal rounds of each double round, 4 row adds and one emit. One
// four-lane quarter-round step unit performs a single add-xor-rotate per lane per cycle, with
// 4 steps per column or diagonal round. The same adders then do the final state add one row
// per cycle. item_stall is high while a word is in work. A finished result waits in the output
// register while the next word is taken, and emit waits while that register is stalled.
module chacha20_stream_cipher_top #(
	parameter int unsigned DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [chacha_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [63:0]                         cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  chacha_pkg::item_t                   item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output chacha_pkg::result_t                 result
);
	import chacha_pkg::*;

	localparam int DRW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
	localparam logic [DRW-1:0] DR_LAST = DRW'(DOUBLE_ROUNDS - 1);

	typedef enum logic [2:0] {S_IDLE, S_LOAD, S_ROUND, S_FINAL, S_EMIT} fsm_t;

	fsm_t         fsm_q;
	key_t         key_q;
	logic [63:0]  nonce_low_q;
	logic [31:0]  nonce_high_q;
	logic [31:0]  init_ctr_q;
	logic [31:0]  ctr_q;
	logic [2:0]   pos_q;
	logic         in_msg_q;
	state_t       x_q;
	logic [63:0]  data_q;
	logic [3:0]   cnt_q;
	logic         last_q;
	logic [1:0]   step_q;
	logic         diag_q;
	logic [DRW-1:0] dr_q;
	logic [1:0]   row_q;
	result_t      result_q;
	logic         result_valid_q;

	state_t       ws;
	logic [3:0][31:0] ws_row;
	logic [31:0]  va [4];
	logic [31:0]  vb [4];
	logic [31:0]  vc [4];
	logic [31:0]  vd [4];
	logic [31:0]  opx [4];
	logic [31:0]  opy [4];
	logic [31:0]  lane_sum [4];
	logic [31:0]  lane_mix [4];
	state_t       x_round;
	state_t       x_final;
	logic [63:0]  ks_word;

	assign ws     = init_state(key_q, nonce_low_q, nonce_high_q, ctr_q);
	assign ws_row = ws[{row_q, 2'b00} +: 4];

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			va[j] = x_q[j];
			vb[j] = diag_q ? x_q[4 + ((j + 1) % 4)] : x_q[4 + j];
			vc[j] = diag_q ? x_q[8 + ((j + 2) % 4)] : x_q[8 + j];
			vd[j] = diag_q ? x_q[12 + ((j + 3) % 4)] : x_q[12 + j];
			if (fsm_q == S_FINAL) begin
				opx[j] = x_q[j];
				opy[j] = ws_row[j];
			end else if (step_q[0]) begin
				opx[j] = vc[j];
				opy[j] = vd[j];
			end else begin
				opx[j] = va[j];
				opy[j] = vb[j];
			end
			lane_sum[j] = opx[j] + opy[j];
			lane_mix[j] = rotl_step((step_q[0] ? vb[j] : vd[j]) ^ lane_sum[j], step_q);
		end
	end

	always_comb begin
		x_round = x_q;
		for (int j = 0; j < 4; j++) begin
			if (!step_q[0]) begin
				x_round[j] = lane_sum[j];
				if (diag_q) begin
					x_round[12 + ((j + 3) % 4)] = lane_mix[j];
				end else begin
					x_round[12 + j] = lane_mix[j];
				end
			end else begin
				if (diag_q) begin
					x_round[8 + ((j + 2) % 4)] = lane_sum[j];
					x_round[4 + ((j + 1) % 4)] = lane_mix[j];
				end else begin
					x_round[8 + j] = lane_sum[j];
					x_round[4 + j] = lane_mix[j];
				end
			end
		end
	end

	// rotate rows: the finished row moves to the bottom
	always_comb begin
		x_final[11:0] = x_q[15:4];
		for (int j = 0; j < 4; j++) begin
			x_final[12 + j] = lane_sum[j];
		end
	end

	assign ks_word = x_q[{pos_q, 1'b0} +: 2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q        <= '0;
			nonce_low_q  <= '0;
			nonce_high_q <= '0;
			init_ctr_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_WORD0:       key_q[0]     <= cfg_data;
				CFG_KEY_WORD1:       key_q[1]     <= cfg_data;
				CFG_KEY_WORD2:       key_q[2]     <= cfg_data;
				CFG_KEY_WORD3:       key_q[3]     <= cfg_data;
				CFG_NONCE_LOW:       nonce_low_q  <= cfg_data;
				CFG_NONCE_HIGH:      nonce_high_q <= cfg_data[31:0];
				CFG_INITIAL_COUNTER: init_ctr_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q          <= S_IDLE;
			ctr_q          <= '0;
			pos_q          <= '0;
			in_msg_q       <= 1'b0;
			x_q            <= '0;
			data_q         <= '0;
			cnt_q          <= '0;
			last_q         <= 1'b0;
			step_q         <= '0;
			diag_q         <= 1'b0;
			dr_q           <= '0;
			row_q          <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall && fsm_q != S_EMIT) begin
				result_valid_q <= 1'b0;
			end
			case (fsm_q)
				S_IDLE: begin
					if (item_valid) begin
						data_q <= item.data_word;
						cnt_q  <= clamp_count(item.byte_count);
						last_q <= item.last_word;
						if (!in_msg_q) begin
							ctr_q <= init_ctr_q;
							pos_q <= '0;
						end
						if (!in_msg_q || pos_q == 3'd0) begin
							fsm_q <= S_LOAD;
						end else begin
							fsm_q <= S_EMIT;
						end
					end
				end
				S_LOAD: begin
					x_q    <= ws;
					step_q <= '0;
					diag_q <= 1'b0;
					dr_q   <= '0;
					fsm_q  <= S_ROUND;
				end
				S_ROUND: begin
					x_q    <= x_round;
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						diag_q <= !diag_q;
						if (diag_q) begin
							if (dr_q == DR_LAST) begin
								row_q <= '0;
								fsm_q <= S_FINAL;
							end else begin
								dr_q <= dr_q + 1'b1;
							end
						end
					end
				end
				S_FINAL: begin
					x_q   <= x_final;
					row_q <= row_q + 2'd1;
					if (row_q == 2'd3) begin
						ctr_q <= ctr_q + 32'd1;
						fsm_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!result_valid_q || !result_stall) begin
						result_q.result_word  <= (data_q ^ ks_word) & byte_mask(cnt_q);
						result_q.result_bytes <= cnt_q;
						result_q.result_last  <= last_q;
						result_valid_q        <= 1'b1;
						if (last_q) begin
							pos_q    <= '0;
							ctr_q    <= init_ctr_q;
							in_msg_q <= 1'b0;
						end else begin
							pos_q    <= pos_q + 3'd1;
							in_msg_q <= 1'b1;
						end
						fsm_q <= S_IDLE;
					end
				end
				default: fsm_q <= S_IDLE;
			endcase
		end
	end

	assign item_stall   = (fsm_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_one_transaction: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("input taken twice in a row");

	a_pos_outside_msg: assert property (@(posedge clk) disable iff (!arst_n)
		!in_msg_q |-> (pos_q == 3'd0))
		else $error("word position nonzero outside a message");

	a_result_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.result_bytes != 4'd0 && result.result_bytes <= 4'd8))
		else $error("result byte count out of range");

endmodule

// File: sim/chacha20_stream_cipher_top_test.sv
`timescale 1ns / 1ps

module chacha20_stream_cipher_top_test;

	import chacha_pkg::*;

	localparam int ROUNDS = DOUBLE_ROUNDS_DEF;
	localparam int N_DIR = 22;
	localparam int N_SETTINGS = 8;
	localparam int WORDS_PER_SETTING = 191;
	localparam int LONG_HOLD_CYCLES = 1200;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  cnt;
		logic        last;
		logic        known;
		logic [63:0] want_word;
		logic [3:0]  want_bytes;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
		{64'h0000000000000000, 4'd8,  1'b0, 1'b1, 64'h903df1a0ade0b876, 4'd8},
		{64'h0000000000000000, 4'd8,  1'b0, 1'b1, 64'h28bd8653e56a5d40, 4'd8},
		{64'h0000000000000000, 4'd8,  1'b1, 1'b1, 64'h1aed8da0b819d2bd, 4'd8},
		{64'hffffffffffffffff, 4'd0,  1'b1, 1'b1, 64'h0000000000000089, 4'd1},
		{64'hffffffffffffffff, 4'd15, 1'b1, 1'b1, 64'h6fc20e5f521f4789, 4'd8},
		{64'h0123456789abcdef, 4'd1,  1'b0, 1'b0, 64'h0, 4'd0},
		{64'hfedcba9876543210, 4'd2,  1'b0, 1'b0, 64'h0, 4'd0},
		{64'h5555555555555555, 4'd3,  1'b0, 1'b0, 64'h0, 4'd0},
		{64'haaaaaaaaaaaaaaaa, 4'd4,  1'b0, 1'b0, 64'h0, 4'd0},
		{64'h0000000000000000, 4'd5,  1'b0, 1'b0, 64'h0, 4'd0},
		{64'hffffffffffffffff, 4'd6,  1'b0, 1'b0, 64'h0, 4'd0},
		{64'h8000000000000001, 4'd7,  1'b0, 1'b0, 64'h0, 4'd0},
		{64'h7fffffffffffffff, 4'd8,  1'b0, 1'b0, 64'h0, 4'd0},
		{64'h0f0f0f0f0f0f0f0f, 4'd9,  1'b0, 1'b0, 64'h0, 4'd0},
		{64'hf0f0f0f0f0f0f0f0, 4'd12, 1'b0, 1'b0, 64'h0, 4'd0},
		{64'h3c3c3c3c3c3c3c3c, 4'd8,  1'b1, 1'b0, 64'h0, 4'd0},
		{64'h1122334455667788, 4'd8,  1'b1, 1'b0, 64'h0, 4'd0},
		{64'hdeadbeefcafef00d, 4'd0,  1'b0, 1'b0, 64'h0, 4'd0},
		{64'hc3c3c3c3c3c3c3c3, 4'd10, 1'b0, 1'b0, 64'h0, 4'd0},
		{64'h00ff00ff00ff00ff, 4'd11, 1'b0, 1'b0, 64'h0, 4'd0},
		{64'hff00ff00ff00ff00, 4'd13, 1'b0, 1'b0, 64'h0, 4'd0},
		{64'h0102040810204080, 4'd14, 1'b1, 1'b0, 64'h0, 4'd0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data = '0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	item_t                item = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;

	chacha20_stream_cipher_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	logic [63:0] key_regs [4];
	logic [63:0] nonce_lo;
	logic [31:0] nonce_hi;
	logic [31:0] start_ctr;
	logic [63:0] ks_words [8];
	logic [31:0] blk_ctr;
	logic [2:0]  word_idx;
	bit          msg_open;

	result_t pending_results [$];

	int     idle_pct;
	int     stall_pct;
	bit     long_hold_req;
	int     faults;
	int     words_sent;
	int     results_seen;
	int     blocks_made;
	int     ctr_wraps;
	int     long_msgs;
	longint cycles;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_results.size());
			$display("chacha20_stream_cipher_top_test: FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic state_t qround(input state_t s, input int a, input int b, input int c,
			input int d);
		s[a] = s[a] + s[b]; s[d] = rotl32(s[d] ^ s[a], 16);
		s[c] = s[c] + s[d]; s[b] = rotl32(s[b] ^ s[c], 12);
		s[a] = s[a] + s[b]; s[d] = rotl32(s[d] ^ s[a], 8);
		s[c] = s[c] + s[d]; s[b] = rotl32(s[b] ^ s[c], 7);
		return s;
	endfunction

	function automatic void refill_keystream();
		state_t seed;
		state_t x;
		seed[0] = SIGMA0;
		seed[1] = SIGMA1;
		seed[2] = SIGMA2;
		seed[3] = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			seed[4 + 2 * i] = key_regs[i][31:0];
			seed[5 + 2 * i] = key_regs[i][63:32];
		end
		seed[12] = blk_ctr;
		seed[13] = nonce_lo[31:0];
		seed[14] = nonce_lo[63:32];
		seed[15] = nonce_hi;
		x = seed;
		for (int r = 0; r < ROUNDS; r++) begin
			x = qround(x, 0, 4, 8, 12);
			x = qround(x, 1, 5, 9, 13);
			x = qround(x, 2, 6, 10, 14);
			x = qround(x, 3, 7, 11, 15);
			x = qround(x, 0, 5, 10, 15);
			x = qround(x, 1, 6, 11, 12);
			x = qround(x, 2, 7, 8, 13);
			x = qround(x, 3, 4, 9, 14);
		end
		for (int i = 0; i < 8; i++)
			ks_words[i] = {x[2 * i + 1] + seed[2 * i + 1], x[2 * i] + seed[2 * i]};
		blocks_made++;
		if (blk_ctr == 32'hffffffff)
			ctr_wraps++;
		blk_ctr = blk_ctr + 32'd1;
	endfunction

	function automatic result_t cipher_word(input item_t w);
		logic [3:0]  n;
		logic [63:0] keep;
		result_t     r;
		if (w.byte_count == 4'd0)
			n = 4'd1;
		else if (w.byte_count > 4'd8)
			n = 4'd8;
		else
			n = w.byte_count;
		if (!msg_open) begin
			blk_ctr = start_ctr;
			word_idx = 3'd0;
		end
		if (word_idx == 3'd0)
			refill_keystream();
		keep = '0;
		for (int b = 0; b < 8; b++)
			if (b < n)
				keep[8 * b +: 8] = 8'hff;
		r.result_word = (w.data_word ^ ks_words[word_idx]) & keep;
		r.result_bytes = n;
		r.result_last = w.last_word;
		word_idx = word_idx + 3'd1;
		if (w.last_word) begin
			word_idx = 3'd0;
			blk_ctr = start_ctr;
			msg_open = 1'b0;
		end else begin
			msg_open = 1'b1;
		end
		return r;
	endfunction

	function automatic void report_fault(input string what, input logic [63:0] want,
			input logic [63:0] got);
		faults++;
		if (faults <= 10)
			$display("result %0d: %s expected %h, got %h", results_seen, what, want, got);
	endfunction

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_fault("unexpected transaction", '0, result.result_word);
			end else begin
				want = pending_results.pop_front();
				if (result.result_word !== want.result_word)
					report_fault("result_word", want.result_word, result.result_word);
				if (result.result_bytes !== want.result_bytes)
					report_fault("result_bytes", 64'(want.result_bytes), 64'(result.result_bytes));
				if (result.result_last !== want.result_last)
					report_fault("result_last", 64'(want.result_last), 64'(result.result_last));
			end
		end
	end

	always begin : output_side
		@(negedge clk);
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			result_stall = 1'b1;
			repeat (LONG_HOLD_CYCLES) @(negedge clk);
			result_stall = 1'b0;
		end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
			result_stall = 1'b1;
			repeat ($urandom_range(1, 19)) @(negedge clk);
			result_stall = 1'b0;
		end else begin
			result_stall = 1'b0;
		end
	end

	task automatic push_word(input item_t w, input bit typed, input result_t typed_result);
		result_t predicted;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		item = w;
		item_valid = 1'b1;
		do @(posedge clk); while (item_stall);
		predicted = cipher_word(w);
		pending_results.push_back(typed ? typed_result : predicted);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		item_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_KEY_WORD0:       key_regs[0] = val;
			CFG_KEY_WORD1:       key_regs[1] = val;
			CFG_KEY_WORD2:       key_regs[2] = val;
			CFG_KEY_WORD3:       key_regs[3] = val;
			CFG_NONCE_LOW:       nonce_lo = val;
			CFG_NONCE_HIGH:      nonce_hi = val[31:0];
			CFG_INITIAL_COUNTER: start_ctr = val[31:0];
			default: ;
		endcase
	endtask

	task automatic load_setting(input int p);
		logic [63:0] k0, k1, k2, k3, nlo, nhi, ictr;
		bit all;
		all = (p < 3);
		case (p)
			0: begin
				k0 = '0; k1 = '0; k2 = '0; k3 = '0;
				nlo = '0; nhi = '0; ictr = '0;
			end
			1: begin
				k0 = '1; k1 = '1; k2 = '1; k3 = '1;
				nlo = '1; nhi = '1; ictr = '1;
			end
			2: begin
				k0 = 64'h0706050403020100;
				k1 = 64'h0f0e0d0c0b0a0908;
				k2 = 64'h1716151413121110;
				k3 = 64'h1f1e1d1c1b1a1918;
				nlo = 64'h4a00000000000000;
				nhi = 64'h0;
				ictr = 64'h1;
			end
			default: begin
				k0 = {$urandom(), $urandom()};
				k1 = {$urandom(), $urandom()};
				k2 = {$urandom(), $urandom()};
				k3 = {$urandom(), $urandom()};
				nlo = {$urandom(), $urandom()};
				nhi = {$urandom(), $urandom()};
				ictr = {$urandom(), $urandom()};
				if ($urandom_range(1))
					ictr[31:0] = 32'hffffffff - 32'($urandom_range(2));
			end
		endcase
		if (all || $urandom_range(1)) write_reg(CFG_KEY_WORD0, k0);
		if (all || $urandom_range(1)) write_reg(CFG_KEY_WORD1, k1);
		if (all || $urandom_range(1)) write_reg(CFG_KEY_WORD2, k2);
		if (all || $urandom_range(1)) write_reg(CFG_KEY_WORD3, k3);
		if (all || $urandom_range(1)) write_reg(CFG_NONCE_LOW, nlo);
		if (all || $urandom_range(1)) write_reg(CFG_NONCE_HIGH, nhi);
		if (all || $urandom_range(1)) write_reg(CFG_INITIAL_COUNTER, ictr);
	endtask

	task automatic run_traffic(input int n_words, input int hold_at, input int pause_at);
		item_t it;
		int sent, len;
		bit noisy;
		sent = 0;
		while (sent < n_words) begin
			noisy = ($urandom_range(9) == 0);
			case ($urandom_range(3))
				0: len = 1;
				1, 2: len = $urandom_range(2, 9);
				default: len = $urandom_range(10, 24);
			endcase
			if (len > 8)
				long_msgs++;
			for (int w = 0; w < len && sent < n_words; w++) begin
				it.data_word = {$urandom(), $urandom()};
				it.last_word = (w == len - 1);
				if (noisy) begin
					it.byte_count = 4'($urandom_range(15));
					if ($urandom_range(3) == 0)
						it.last_word = !it.last_word;
				end else begin
					it.byte_count = it.last_word ? 4'($urandom_range(1, 8)) : 4'd8;
				end
				if (sent == hold_at)
					long_hold_req = 1'b1;
				if (sent == pause_at)
					drain_results();
				push_word(it, 1'b0, '0);
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		item_t    it;
		dir_row_t row;
		key_regs = '{default: '0};
		nonce_lo = '0;
		nonce_hi = '0;
		start_ctr = '0;
		ks_words = '{default: '0};
		blk_ctr = '0;
		word_idx = '0;
		msg_open = 1'b0;
		idle_pct = 20;
		stall_pct = 20;
		long_hold_req = 1'b0;
		faults = 0;
		words_sent = 0;
		results_seen = 0;
		blocks_made = 0;
		ctr_wraps = 0;
		long_msgs = 0;
		cycles = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			row = DIR_ROWS[i];
			it.data_word = row.data;
			it.byte_count = row.cnt;
			it.last_word = row.last;
			push_word(it, row.known, {row.want_word, row.want_bytes, row.last});
		end
		drain_results();

		for (int p = 0; p < N_SETTINGS; p++) begin
			load_setting(p);
			if (p == N_SETTINGS - 1) begin
				idle_pct = 0;
				stall_pct = 0;
			end else begin
				case ($urandom_range(3))
					0: idle_pct = 0;
					1: idle_pct = 10;
					2: idle_pct = 30;
					default: idle_pct = 60;
				endcase
				case ($urandom_range(3))
					0: stall_pct = 0;
					1: stall_pct = 10;
					2: stall_pct = 30;
					default: stall_pct = 60;
				endcase
			end
			run_traffic(WORDS_PER_SETTING, (p == 3) ? 30 : -1, (p == 5) ? 95 : -1);
			drain_results();
		end

		repeat (400) @(posedge clk);
		faults += pending_results.size();

		$display("%0d words in, %0d results checked over %0d key/nonce/counter settings",
			words_sent, results_seen, N_SETTINGS + 1);
		$display("%0d keystream blocks, %0d counter wraps, %0d messages past one block",
			blocks_made, ctr_wraps, long_msgs);
		if (faults == 0)
			$display("chacha20_stream_cipher_top_test: PASS");
		else
			$display("chacha20_stream_cipher_top_test: FAIL");
		$finish;
	end

endmodule

// File: sim.f
src/chacha_pkg.sv
src/chacha20_stream_cipher_top.sv
sim/chacha20_stream_cipher_top_test.sv
